// ===== rtl/core/nrve_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrve_pkg: shared types, constants and helpers
// Queue word layout, character codes, parser state codes and the small lookup
// functions used by the front and back parts of the RMC variation extractor.
// ----------------------------------------------------------------------------
package nrve_pkg;

    // Default parameter values
    localparam int MAX_LEN_DEF     = 255;
    localparam int WS_HOLD_DEF     = 4;
    localparam int FRAC_DIGITS_DEF = 3;
    localparam int QUEUE_DEPTH_DEF = 4;

    // Fixed sizes
    localparam int VAL_W        = 20;
    localparam int OUT_W        = 21;
    localparam int TAIL_DEPTH   = 3;
    localparam int PREFIX_LEN   = 6;
    localparam int LIMIT_DIGITS = 6;

    localparam logic [VAL_W-1:0] VAR_LIMIT = 20'd1000000;

    // Field counting
    localparam logic [3:0] COMMA_SAT  = 4'd12;
    localparam logic [3:0] MIN_COMMAS = 4'd11;
    localparam logic [3:0] VAR_FIELD  = 4'd10;
    localparam logic [3:0] DIR_FIELD  = 4'd11;

    // Character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_WEST  = 8'h57;

    // Checksum star phase
    localparam logic [1:0] SP_NONE  = 2'd0;
    localparam logic [1:0] SP_HI    = 2'd1;
    localparam logic [1:0] SP_LO    = 2'd2;
    localparam logic [1:0] SP_DONE  = 2'd3;

    // Number parser states
    localparam logic [2:0] NS_LEAD  = 3'd0;
    localparam logic [2:0] NS_SIGN  = 3'd1;
    localparam logic [2:0] NS_INT   = 3'd2;
    localparam logic [2:0] NS_DOT0  = 3'd3;
    localparam logic [2:0] NS_FRAC  = 3'd4;
    localparam logic [2:0] NS_TRAIL = 3'd5;
    localparam logic [2:0] NS_BAD   = 3'd6;

    // Direction field match
    localparam logic [1:0] WM_EMPTY = 2'd0;
    localparam logic [1:0] WM_WEST  = 2'd1;
    localparam logic [1:0] WM_OTHER = 2'd2;

    // One word between front and back: a committed byte or an end marker
    typedef struct packed {
        logic       is_end;
        logic [7:0] data;
    } nrve_word_t;

    function automatic logic is_space(input logic [7:0] b);
        return b inside {8'd32, [8'd9:8'd13]};
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return b inside {[8'h30:8'h39]};
    endfunction

    // Hex digit decode: bit 4 flags a valid digit, bits 3:0 carry its value
    function automatic logic [4:0] hex_decode(input logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b inside {[8'h30:8'h39]})
            r = {1'b1, b[3:0]};
        else if (b inside {[8'h41:8'h46], [8'h61:8'h66]})
            r = {1'b1, 4'(b[2:0] + 3'd1) + 4'd8};
        return r;
    endfunction

    // Expected sentence tag, one character per position
    function automatic logic [7:0] rmc_tag_char(input logic [2:0] pos);
        logic [7:0] c;
        case (pos)
            3'd0:    c = 8'h24;
            3'd1:    c = 8'h47;
            3'd2:    c = 8'h50;
            3'd3:    c = 8'h52;
            3'd4:    c = 8'h4D;
            3'd5:    c = 8'h43;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // Powers of ten up to the saturation limit
    function automatic logic [VAL_W-1:0] pow10(input logic [2:0] k);
        logic [VAL_W-1:0] p;
        case (k)
            3'd0:    p = 20'd1;
            3'd1:    p = 20'd10;
            3'd2:    p = 20'd100;
            3'd3:    p = 20'd1000;
            3'd4:    p = 20'd10000;
            3'd5:    p = 20'd100000;
            3'd6:    p = 20'd1000000;
            default: p = 20'd1;
        endcase
        return p;
    endfunction

endpackage

// ===== rtl/core/nmea_rmc_variation_extractor_top.sv =====
`timescale 1ns / 1ps
// Throughput: one byte per cycle while item_stall is low. A byte that leaves bytes to
//   drain from the hold (itself and the whitespace behind it) stalls the input while they
//   drain, and if it ends the line, until the end marker is queued. The back part registers
//   the result when the end marker leaves the queue; a stalled result holds the end
//   marker, and the queue behind it then fills and stalls the input.
// Reset: asynchronous, active low; no clearing pass, input taken at once.
// ----------------------------------------------------------------------------
// nmea_rmc_variation_extractor_top: NMEA RMC checksum and variation parser
// Front part takes sentence bytes and trims trailing whitespace, a short
// queue decouples it from the back part that checks and parses the sentence.
// ----------------------------------------------------------------------------
module nmea_rmc_variation_extractor_top
    import nrve_pkg::*;
#(
    parameter int MAX_LEN     = MAX_LEN_DEF,
    parameter int WS_HOLD     = WS_HOLD_DEF,
    parameter int FRAC_DIGITS = FRAC_DIGITS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    item_valid,
    output logic                    item_stall,
    input  logic [7:0]              char_in,
    input  logic                    end_of_line,
    output logic                    result_valid,
    input  logic                    result_stall,
    output logic                    checksum_ok,
    output logic                    is_rmc,
    output logic                    variation_found,
    output logic signed [OUT_W-1:0] variation_milli
);

    logic       q_push;
    nrve_word_t q_word;
    logic       q_full;
    logic       q_pop;
    logic       q_head_valid;
    nrve_word_t q_head_word;

    // Intake and whitespace hold
    nrve_front #(
        .MAX_LEN (MAX_LEN),
        .WS_HOLD (WS_HOLD)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .char_in    (char_in),
        .end_of_line(end_of_line),
        .q_push     (q_push),
        .q_word     (q_word),
        .q_full     (q_full)
    );

    // Decoupling queue
    nrve_queue #(
        .DEPTH (QUEUE_DEPTH_DEF)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_word  (q_word),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_word  (q_head_word)
    );

    // Checksum and field parser
    nrve_back #(
        .FRAC_DIGITS (FRAC_DIGITS)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .head_valid      (q_head_valid),
        .head_word       (q_head_word),
        .pop             (q_pop),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .checksum_ok     (checksum_ok),
        .is_rmc          (is_rmc),
        .variation_found (variation_found),
        .variation_milli (variation_milli)
    );

endmodule

// ===== rtl/core/nrve_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrve_front: byte intake and whitespace hold
// Counts and closes the sentence, holds trailing whitespace, and pushes
// committed bytes and an end marker into the queue, one word per cycle while the queue has room.
// ----------------------------------------------------------------------------
module nrve_front
    import nrve_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEF,
    parameter int WS_HOLD = WS_HOLD_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_stall,
    input  logic [7:0] char_in,
    input  logic       end_of_line,
    output logic       q_push,
    output nrve_word_t q_word,
    input  logic       q_full
);

    localparam int HOLD_N = WS_HOLD + 1;
    localparam int CNT_W  = $clog2(HOLD_N + 1);
    localparam int IDX_W  = $clog2(MAX_LEN + 1);

    logic [7:0]       hold_reg [HOLD_N];
    logic [7:0]       hold_next [HOLD_N];
    logic [CNT_W-1:0] hold_cnt_reg, hold_cnt_next;
    logic [CNT_W-1:0] drain_cnt_reg, drain_cnt_next;
    logic             eol_pend_reg, eol_pend_next;
    logic             closed_reg, closed_next;
    logic [IDX_W-1:0] byte_idx_reg, byte_idx_next;

    logic pop;
    logic end_push;
    logic accept;
    logic take;

    // Drain held bytes first, then the end marker once no byte is left to drain
    assign pop      = (drain_cnt_reg != '0) && !q_full;
    assign end_push = eol_pend_reg && (drain_cnt_reg == '0) && !q_full;

    assign q_push        = pop || end_push;
    assign q_word.is_end = end_push;
    assign q_word.data   = hold_reg[0];

    // Hold the input while bytes wait to drain or an end waits to go out
    assign item_stall = ((drain_cnt_reg - CNT_W'(pop)) != '0) ||
                        (eol_pend_reg && !end_push);
    assign accept     = item_valid && !item_stall;

    always_comb
    begin
        hold_next      = hold_reg;
        hold_cnt_next  = hold_cnt_reg;
        drain_cnt_next = drain_cnt_reg;
        eol_pend_next  = eol_pend_reg;
        closed_next    = closed_reg;
        byte_idx_next  = byte_idx_reg;
        take           = 1'b0;

        // Retire the word sent this cycle
        if (end_push)
        begin
            hold_cnt_next = '0;
            eol_pend_next = 1'b0;
            closed_next   = 1'b0;
            byte_idx_next = '0;
        end
        else if (pop)
        begin
            for (int i = 0; i < HOLD_N - 1; i++)
                hold_next[i] = hold_reg[i + 1];
            hold_cnt_next  = hold_cnt_reg - CNT_W'(1);
            drain_cnt_next = drain_cnt_reg - CNT_W'(1);
        end

        // Take the new byte into the hold
        if (accept)
        begin
            if (!closed_next)
            begin
                if (char_in == CH_NUL || byte_idx_next >= IDX_W'(MAX_LEN))
                    closed_next = 1'b1;
                else
                    take = 1'b1;
            end
            if (take)
            begin
                byte_idx_next = byte_idx_next + IDX_W'(1);
                for (int i = 0; i < HOLD_N; i++)
                    if (hold_cnt_next == CNT_W'(i))
                        hold_next[i] = char_in;
                if (is_space(char_in))
                begin
                    if (hold_cnt_next == CNT_W'(WS_HOLD))
                        drain_cnt_next = CNT_W'(1);
                end
                else
                begin
                    drain_cnt_next = hold_cnt_next + CNT_W'(1);
                end
                hold_cnt_next = hold_cnt_next + CNT_W'(1);
            end
            if (end_of_line)
                eol_pend_next = 1'b1;
        end
    end

    // Hold storage
    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_cnt_reg  <= '0;
            drain_cnt_reg <= '0;
            eol_pend_reg  <= 1'b0;
            closed_reg    <= 1'b0;
            byte_idx_reg  <= '0;
        end
        else
        begin
            hold_cnt_reg  <= hold_cnt_next;
            drain_cnt_reg <= drain_cnt_next;
            eol_pend_reg  <= eol_pend_next;
            closed_reg    <= closed_next;
            byte_idx_reg  <= byte_idx_next;
        end
    end

    // Only held bytes can be drained
    assert property (@(posedge clk) disable iff (!rst_n)
        drain_cnt_reg <= hold_cnt_reg)
        else $error("front drain count exceeds hold count");

    // A full hold always has a byte scheduled to leave
    assert property (@(posedge clk) disable iff (!rst_n)
        hold_cnt_reg == CNT_W'(HOLD_N) |-> drain_cnt_reg != '0)
        else $error("front hold full with nothing draining");

endmodule

// ===== rtl/core/nrve_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrve_queue: word queue between front and back
// Small first-in first-out buffer that lets the intake and the parser stall
// independently of each other.
// ----------------------------------------------------------------------------
module nrve_queue
    import nrve_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  nrve_word_t push_word,
    output logic       full,
    input  logic       pop,
    output logic       head_valid,
    output nrve_word_t head_word
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    nrve_word_t       slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    logic do_push;
    logic do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_word  = slot_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // Store the incoming word
    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_word;
    end

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            if (do_push && !do_pop)
                count_reg <= count_reg + CNT_W'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - CNT_W'(1);
        end
    end

    // A push into a full queue would lose a word
    assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("queue push while full");

endmodule

// ===== rtl/core/nrve_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrve_back: checksum and RMC field parser
// Takes one committed byte per cycle, unless an end marker ahead of it waits for
// the result slot: runs the XOR check, delays bytes by the three-byte tail,
// matches the tag, counts fields and parses the variation.
// ----------------------------------------------------------------------------
module nrve_back
    import nrve_pkg::*;
#(
    parameter int FRAC_DIGITS = FRAC_DIGITS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    head_valid,
    input  nrve_word_t              head_word,
    output logic                    pop,
    output logic                    result_valid,
    input  logic                    result_stall,
    output logic                    checksum_ok,
    output logic                    is_rmc,
    output logic                    variation_found,
    output logic signed [OUT_W-1:0] variation_milli
);

    localparam int FD_W = $clog2(FRAC_DIGITS + 1);

    // Parser state
    logic             committed_reg, committed_next;
    logic [7:0]       xor_sum_reg, xor_sum_next;
    logic [1:0]       star_reg, star_next;
    logic [4:0]       hex_pair_reg, hex_pair_next;
    logic             tail_v_reg [TAIL_DEPTH];
    logic             tail_v_next [TAIL_DEPTH];
    logic [7:0]       tail_b_reg [TAIL_DEPTH];
    logic [7:0]       tail_b_next [TAIL_DEPTH];
    logic             prefix_ok_reg, prefix_ok_next;
    logic [2:0]       prefix_pos_reg, prefix_pos_next;
    logic [3:0]       comma_reg, comma_next;
    logic [2:0]       num_state_reg, num_state_next;
    logic             minus_reg, minus_next;
    logic [VAL_W-1:0] acc_reg, acc_next;
    logic [FD_W-1:0]  frac_reg, frac_next;
    logic [1:0]       west_reg, west_next;

    // Result register
    logic                    out_valid_reg;
    logic                    ok_reg;
    logic                    rmc_reg;
    logic                    found_reg;
    logic signed [OUT_W-1:0] var_reg;

    logic             out_free;
    logic             do_commit;
    logic             do_end;
    logic [7:0]       b;
    logic [7:0]       ob;
    logic [4:0]       hv;
    logic             res_ok;
    logic             res_rmc;
    logic             res_found;
    logic             res_neg;
    logic [2:0]       shift_k;
    logic [VAL_W-1:0] scale;
    logic [VAL_W-1:0] thresh;
    logic [2*VAL_W-1:0] prod;
    logic [VAL_W-1:0] mag;
    logic [OUT_W-1:0] mag_ext;
    logic [OUT_W-1:0] res_var;

    function automatic logic [VAL_W-1:0] take_digit(input logic [VAL_W-1:0] acc,
                                                    input logic [3:0] d);
        logic [VAL_W+3:0] v;
        v = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {{VAL_W{1'b0}}, d};
        return (v > (VAL_W + 4)'(VAR_LIMIT)) ? VAR_LIMIT : v[VAL_W-1:0];
    endfunction

    // Take commits freely; take the end marker only when the result slot frees
    assign out_free  = !out_valid_reg || !result_stall;
    assign pop       = head_valid && (!head_word.is_end || out_free);
    assign do_commit = pop && !head_word.is_end;
    assign do_end    = pop && head_word.is_end;
    assign b         = head_word.data;
    assign ob        = tail_b_reg[0];
    assign hv        = hex_decode(b);

    // Per-byte update
    always_comb
    begin
        committed_next  = committed_reg;
        xor_sum_next    = xor_sum_reg;
        star_next       = star_reg;
        hex_pair_next   = hex_pair_reg;
        tail_v_next     = tail_v_reg;
        tail_b_next     = tail_b_reg;
        prefix_ok_next  = prefix_ok_reg;
        prefix_pos_next = prefix_pos_reg;
        comma_next      = comma_reg;
        num_state_next  = num_state_reg;
        minus_next      = minus_reg;
        acc_next        = acc_reg;
        frac_next       = frac_reg;
        west_next       = west_reg;

        if (do_end)
        begin
            // Return to the start of a sentence
            committed_next  = 1'b0;
            xor_sum_next    = '0;
            star_next       = SP_NONE;
            hex_pair_next   = '0;
            for (int i = 0; i < TAIL_DEPTH; i++)
                tail_v_next[i] = 1'b0;
            prefix_ok_next  = 1'b1;
            prefix_pos_next = '0;
            comma_next      = '0;
            num_state_next  = NS_LEAD;
            minus_next      = 1'b0;
            acc_next        = '0;
            frac_next       = '0;
            west_next       = WM_EMPTY;
        end
        else if (do_commit)
        begin
            committed_next = 1'b1;

            // Checksum: skip the first byte, sum up to the star, then the hex pair
            if (committed_reg)
            begin
                case (star_reg)
                    SP_NONE:
                    begin
                        if (b == CH_STAR)
                            star_next = SP_HI;
                        else
                            xor_sum_next = xor_sum_reg ^ b;
                    end
                    SP_HI:
                    begin
                        hex_pair_next = hv;
                        star_next     = SP_LO;
                    end
                    SP_LO:
                    begin
                        if (hex_pair_reg[4] && hv[4])
                            xor_sum_next = xor_sum_reg ^ {hex_pair_reg[3:0], hv[3:0]};
                        star_next = SP_DONE;
                    end
                    default:
                    begin
                        star_next = star_reg;
                    end
                endcase
            end

            // Advance the tail delay
            for (int i = 0; i < TAIL_DEPTH - 1; i++)
            begin
                tail_v_next[i] = tail_v_reg[i + 1];
                tail_b_next[i] = tail_b_reg[i + 1];
            end
            tail_v_next[TAIL_DEPTH-1] = 1'b1;
            tail_b_next[TAIL_DEPTH-1] = b;

            // Parse the byte leaving the tail
            if (tail_v_reg[0])
            begin
                if (prefix_pos_reg < 3'(PREFIX_LEN))
                begin
                    if (ob != rmc_tag_char(prefix_pos_reg))
                        prefix_ok_next = 1'b0;
                    prefix_pos_next = prefix_pos_reg + 3'd1;
                end

                if (ob == CH_COMMA)
                begin
                    if (comma_reg < COMMA_SAT)
                        comma_next = comma_reg + 4'd1;
                end
                else if (comma_reg == VAR_FIELD)
                begin
                    case (num_state_reg)
                        NS_LEAD, NS_SIGN:
                        begin
                            if (num_state_reg == NS_LEAD && is_space(ob))
                                num_state_next = NS_LEAD;
                            else if (num_state_reg == NS_LEAD && ob == CH_PLUS)
                                num_state_next = NS_SIGN;
                            else if (num_state_reg == NS_LEAD && ob == CH_MINUS)
                            begin
                                num_state_next = NS_SIGN;
                                minus_next     = 1'b1;
                            end
                            else if (is_digit(ob))
                            begin
                                acc_next       = take_digit(acc_reg, ob[3:0]);
                                num_state_next = NS_INT;
                            end
                            else if (ob == CH_DOT)
                                num_state_next = NS_DOT0;
                            else
                                num_state_next = NS_BAD;
                        end
                        NS_INT:
                        begin
                            if (is_digit(ob))
                                acc_next = take_digit(acc_reg, ob[3:0]);
                            else if (ob == CH_DOT)
                                num_state_next = NS_FRAC;
                            else if (is_space(ob))
                                num_state_next = NS_TRAIL;
                            else
                                num_state_next = NS_BAD;
                        end
                        NS_DOT0, NS_FRAC:
                        begin
                            if (is_digit(ob))
                            begin
                                if (frac_reg < FD_W'(FRAC_DIGITS))
                                begin
                                    acc_next  = take_digit(acc_reg, ob[3:0]);
                                    frac_next = frac_reg + FD_W'(1);
                                end
                                num_state_next = NS_FRAC;
                            end
                            else if (is_space(ob) && num_state_reg == NS_FRAC)
                                num_state_next = NS_TRAIL;
                            else
                                num_state_next = NS_BAD;
                        end
                        NS_TRAIL:
                        begin
                            if (!is_space(ob))
                                num_state_next = NS_BAD;
                        end
                        default:
                        begin
                            num_state_next = NS_BAD;
                        end
                    endcase
                end
                else if (comma_reg == DIR_FIELD)
                begin
                    west_next = (west_reg == WM_EMPTY && ob == CH_WEST) ? WM_WEST : WM_OTHER;
                end
            end
        end
    end

    // Result: scale missing fraction digits, saturate, apply sign
    assign res_ok    = (star_reg == SP_NONE || star_reg == SP_DONE) && (xor_sum_reg == 8'd0);
    assign res_rmc   = res_ok && prefix_ok_reg && (prefix_pos_reg >= 3'(PREFIX_LEN));
    assign res_found = res_rmc && (comma_reg >= MIN_COMMAS) &&
                       (num_state_reg inside {NS_INT, NS_FRAC, NS_TRAIL});
    assign shift_k   = 3'(FRAC_DIGITS) - 3'(frac_reg);
    assign scale     = pow10(shift_k);
    assign thresh    = pow10(3'(LIMIT_DIGITS) - shift_k);
    assign prod      = acc_reg * scale;
    assign mag       = (acc_reg > thresh) ? VAR_LIMIT : prod[VAL_W-1:0];
    assign res_neg   = minus_reg != (west_reg == WM_WEST);
    assign mag_ext   = {1'b0, mag};
    assign res_var   = res_found ? (res_neg ? (~mag_ext + OUT_W'(1)) : mag_ext) : '0;

    // Parser storage
    always_ff @(posedge clk)
    begin
        tail_b_reg <= tail_b_next;
        if (do_end && committed_reg)
        begin
            ok_reg    <= res_ok;
            rmc_reg   <= res_rmc;
            found_reg <= res_found;
            var_reg   <= $signed(res_var);
        end
    end

    // Parser control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            committed_reg  <= 1'b0;
            xor_sum_reg    <= '0;
            star_reg       <= SP_NONE;
            hex_pair_reg   <= '0;
            for (int i = 0; i < TAIL_DEPTH; i++)
                tail_v_reg[i] <= 1'b0;
            prefix_ok_reg  <= 1'b1;
            prefix_pos_reg <= '0;
            comma_reg      <= '0;
            num_state_reg  <= NS_LEAD;
            minus_reg      <= 1'b0;
            acc_reg        <= '0;
            frac_reg       <= '0;
            west_reg       <= WM_EMPTY;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            committed_reg  <= committed_next;
            xor_sum_reg    <= xor_sum_next;
            star_reg       <= star_next;
            hex_pair_reg   <= hex_pair_next;
            tail_v_reg     <= tail_v_next;
            prefix_ok_reg  <= prefix_ok_next;
            prefix_pos_reg <= prefix_pos_next;
            comma_reg      <= comma_next;
            num_state_reg  <= num_state_next;
            minus_reg      <= minus_next;
            acc_reg        <= acc_next;
            frac_reg       <= frac_next;
            west_reg       <= west_next;
            if (do_end && committed_reg)
                out_valid_reg <= 1'b1;
            else if (!result_stall)
                out_valid_reg <= 1'b0;
        end
    end

    assign result_valid    = out_valid_reg;
    assign checksum_ok     = ok_reg;
    assign is_rmc          = rmc_reg;
    assign variation_found = found_reg;
    assign variation_milli = var_reg;

    // Result flags nest: found needs rmc, rmc needs a good checksum
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (!found_reg || rmc_reg) && (!rmc_reg || ok_reg))
        else $error("result flags inconsistent");

    // No value without a parsed field, and the value stays inside the limit
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (found_reg || var_reg == '0) &&
                          (var_reg <= $signed({1'b0, VAR_LIMIT})) &&
                          (var_reg >= -$signed({1'b0, VAR_LIMIT})))
        else $error("variation out of range");

    // Fraction digit count never passes its limit
    assert property (@(posedge clk) disable iff (!rst_n)
        frac_reg <= FD_W'(FRAC_DIGITS))
        else $error("fraction digit count overflow");

endmodule
